### rtl/core/c2sa_pkg.sv
// c2sa_pkg: widths, angle constants, the arctangent table and the flag type
// shared by the Cartesian-to-spherical angle pipeline.
// No dependencies.
package c2sa_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // Square-root section: 64-bit radicand, one root bit per stage
  localparam int SQRT_W = 64;
  localparam int ROOT_W = 32;

  // CORDIC vectoring section
  localparam int CORDIC_STEPS  = 23;
  localparam int CORDIC_W      = 49;   // holds about 2^46.5 with gain
  localparam int CORDIC_TOP    = 46;   // operands are scaled to 2^45
  localparam int PITCH_A_SHIFT = 14;   // horizontal length has 32-W fraction bits
  localparam int ANG_W         = 25;   // signed accumulator, 1/65536 deg
  localparam int ATAN_W        = 22;

  // Angles
  localparam int Q16_W          = 25;  // unsigned angle, 1/65536 deg
  localparam int DEG_W          = 17;  // yaw out, 1/256 deg
  localparam int NPITCH_W       = 18;
  localparam int DEG90_Q16      = 5898240;
  localparam int DEG180_Q16     = 11796480;
  localparam int DEG360_Q16     = 23592960;
  localparam int TURN_256       = 92160;
  localparam int PITCH_UP_256   = 23040;
  localparam int PITCH_DOWN_256 = 69120;
  localparam int ROUND_HALF     = 128;

  // atan(2^-i), 1/65536 deg
  localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1
  };

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic z_pos;
    logic z_neg;
    logic vertical;   // x and y both zero
  } flags_t;

  // Accumulator clamped to 0 .. 90 deg
  function automatic logic [Q16_W-1:0] clamp_q16(input logic signed [ANG_W-1:0] ang);
    logic [Q16_W-1:0] res;
    priority if (ang < 0) begin
      res = '0;
    end else if (ang > DEG90_Q16) begin
      res = Q16_W'(DEG90_Q16);
    end else begin
      res = Q16_W'(ang);
    end
    return res;
  endfunction

  // Round half up to 1/256 deg; a full turn reads as zero
  function automatic logic [DEG_W-1:0] to_256ths(input logic [Q16_W-1:0] q);
    logic [Q16_W-1:0] sum;
    logic [DEG_W-1:0] r;
    sum = q + Q16_W'(ROUND_HALF);
    r   = DEG_W'(sum >> 8);
    if (r >= DEG_W'(TURN_256)) begin
      r = r - DEG_W'(TURN_256);
    end
    return r;
  endfunction

endpackage

### rtl/core/cartesian_to_spherical_angles.sv
// cartesian_to_spherical_angles: top level, front end, delay lines and angle
// finishing. Depends on c2sa_pkg, c2sa_sqrt and c2sa_cordic.
//
// Converts a signed 3D vector to its floored length, its yaw (atan2(y,x)) and
// its negated pitch, both angles in 1/256 deg and wrapped to [0,360) before
// the pitch is negated. An item is taken on every clock edge with start high
// and busy low; busy is high only while rst_n is low, so a new item may enter
// every cycle. Each item comes out as a one-cycle out_valid strobe with the
// three result ports; the receiver cannot stall it. The pipeline is made of
// three front-end stages (abs, squares, sums), 32 square-root stages (one
// root bit each, on the 64-bit radicands of the length and of the horizontal
// length, the two roots side by side), 23 CORDIC micro-rotation stages
// running yaw and pitch side by side, and two finishing stages (quadrant
// mapping, then rounding and wrap). A vertical vector (x and y zero, the
// zero vector too) gives yaw 0 and pitch 90 deg when z is positive, 270 deg
// otherwise. Results lie within one LSB of exact values.
module cartesian_to_spherical_angles #(
  parameter int COORD_WIDTH = c2sa_pkg::COORD_WIDTH_DEF   // 8 .. 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_WIDTH-1:0]        in_vec_x,
  input  logic signed [COORD_WIDTH-1:0]        in_vec_y,
  input  logic signed [COORD_WIDTH-1:0]        in_vec_z,
  output logic                                 out_valid,
  output logic [COORD_WIDTH-1:0]               out_magnitude,
  output logic [c2sa_pkg::DEG_W-1:0]           out_yaw_angle,
  output logic signed [c2sa_pkg::NPITCH_W-1:0] out_neg_pitch
);
  import c2sa_pkg::*;

  localparam int W       = COORD_WIDTH;
  localparam int SQ_W    = 2 * W;
  localparam int CSHIFT  = CORDIC_TOP - W;       // components to 2^45 scale
  localparam int RAD_SH  = SQRT_W - SQ_W;        // 2*(32-W) fraction bits
  localparam int LATENCY = 3 + ROOT_W + CORDIC_STEPS + 2;

  // Busy only in reset: the pipeline itself never refuses an item
  assign busy = ~rst_n;

  // ---------------------------------------------------------------------
  // Stage 1: magnitudes and sign flags
  // ---------------------------------------------------------------------
  logic         s1_v_r, s1_v_nxt;
  logic [W-1:0] s1_ax_r, s1_ay_r, s1_az_r;
  logic [W-1:0] s1_ax_nxt, s1_ay_nxt, s1_az_nxt;
  flags_t       s1_fl_r, s1_fl_nxt;

  always_comb begin
    s1_v_nxt           = start & ~busy;
    // the most negative value maps onto its own bit pattern, read unsigned
    s1_ax_nxt          = in_vec_x[W-1] ? $unsigned(-in_vec_x) : $unsigned(in_vec_x);
    s1_ay_nxt          = in_vec_y[W-1] ? $unsigned(-in_vec_y) : $unsigned(in_vec_y);
    s1_az_nxt          = in_vec_z[W-1] ? $unsigned(-in_vec_z) : $unsigned(in_vec_z);
    s1_fl_nxt.x_neg    = in_vec_x[W-1];
    s1_fl_nxt.y_neg    = in_vec_y[W-1];
    s1_fl_nxt.z_neg    = in_vec_z[W-1];
    s1_fl_nxt.z_pos    = ~in_vec_z[W-1] && (in_vec_z != '0);
    s1_fl_nxt.vertical = (in_vec_x == '0) && (in_vec_y == '0);
  end

  // ---------------------------------------------------------------------
  // Stage 2: squares
  // ---------------------------------------------------------------------
  logic            s2_v_r;
  logic [SQ_W-1:0] s2_sqx_r, s2_sqy_r, s2_sqz_r;
  logic [W-1:0]    s2_ax_r, s2_ay_r, s2_az_r;
  flags_t          s2_fl_r;

  // ---------------------------------------------------------------------
  // Stage 3: horizontal and full squared length, scaled to the radicand
  // ---------------------------------------------------------------------
  logic              s3_v_r;
  logic [SQRT_W-1:0] s3_hsq_r, s3_tot_r, s3_hsq_nxt, s3_tot_nxt;
  logic [W-1:0]      s3_ax_r, s3_ay_r, s3_az_r;
  flags_t            s3_fl_r;
  logic [SQ_W-1:0]   hsq, tot;

  always_comb begin
    hsq        = s2_sqx_r + s2_sqy_r;     // at most 2^(2W-1)
    tot        = hsq + s2_sqz_r;          // at most 3 * 2^(2W-2)
    s3_hsq_nxt = SQRT_W'(hsq) << RAD_SH;
    s3_tot_nxt = SQRT_W'(tot) << RAD_SH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ax_r  <= s1_ax_nxt;
    s1_ay_r  <= s1_ay_nxt;
    s1_az_r  <= s1_az_nxt;
    s1_fl_r  <= s1_fl_nxt;
    s2_sqx_r <= SQ_W'(s1_ax_r) * SQ_W'(s1_ax_r);
    s2_sqy_r <= SQ_W'(s1_ay_r) * SQ_W'(s1_ay_r);
    s2_sqz_r <= SQ_W'(s1_az_r) * SQ_W'(s1_az_r);
    s2_ax_r  <= s1_ax_r;
    s2_ay_r  <= s1_ay_r;
    s2_az_r  <= s1_az_r;
    s2_fl_r  <= s1_fl_r;
    s3_hsq_r <= s3_hsq_nxt;
    s3_tot_r <= s3_tot_nxt;
    s3_ax_r  <= s2_ax_r;
    s3_ay_r  <= s2_ay_r;
    s3_az_r  <= s2_az_r;
    s3_fl_r  <= s2_fl_r;
  end

  // ---------------------------------------------------------------------
  // Square roots. The full length is taken at the same scale as the
  // horizontal one; its top W root bits are the floored length.
  // ---------------------------------------------------------------------
  logic              sqm_v, sqf_v;
  logic [ROOT_W-1:0] root_m, root_f;

  c2sa_sqrt u_sqrt_mag (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s3_v_r),
    .rad_i   (s3_tot_r),
    .valid_o (sqm_v),
    .root_o  (root_m)
  );

  c2sa_sqrt u_sqrt_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s3_v_r),
    .rad_i   (s3_hsq_r),
    .valid_o (sqf_v),
    .root_o  (root_f)
  );

  // Components and flags ride alongside the root stages
  logic [W-1:0] ax_d_r [ROOT_W];
  logic [W-1:0] ay_d_r [ROOT_W];
  logic [W-1:0] az_d_r [ROOT_W];
  flags_t       fl1_d_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_dly1
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        ax_d_r[i]  <= s3_ax_r;
        ay_d_r[i]  <= s3_ay_r;
        az_d_r[i]  <= s3_az_r;
        fl1_d_r[i] <= s3_fl_r;
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        ax_d_r[i]  <= ax_d_r[i-1];
        ay_d_r[i]  <= ay_d_r[i-1];
        az_d_r[i]  <= az_d_r[i-1];
        fl1_d_r[i] <= fl1_d_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC: yaw on (|x|, |y|), pitch on (horizontal length, |z|)
  // ---------------------------------------------------------------------
  logic                    yaw_v, pit_v;
  logic signed [ANG_W-1:0] yaw_ang, pit_ang;
  logic [CORDIC_W-1:0]     yaw_a, yaw_b, pit_a, pit_b;
  logic [W-1:0]            mag_in;

  always_comb begin
    yaw_a  = CORDIC_W'(ax_d_r[ROOT_W-1]) << CSHIFT;
    yaw_b  = CORDIC_W'(ay_d_r[ROOT_W-1]) << CSHIFT;
    pit_a  = CORDIC_W'(root_f) << PITCH_A_SHIFT;
    pit_b  = CORDIC_W'(az_d_r[ROOT_W-1]) << CSHIFT;
    mag_in = root_m[ROOT_W-1:ROOT_W-W];
  end

  c2sa_cordic u_cordic_yaw (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (sqm_v),
    .a_i     (yaw_a),
    .b_i     (yaw_b),
    .valid_o (yaw_v),
    .ang_o   (yaw_ang)
  );

  c2sa_cordic u_cordic_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (sqf_v),
    .a_i     (pit_a),
    .b_i     (pit_b),
    .valid_o (pit_v),
    .ang_o   (pit_ang)
  );

  // Length and flags ride alongside the CORDIC stages
  logic [W-1:0] mag_d_r [CORDIC_STEPS];
  flags_t       fl2_d_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_dly2
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        mag_d_r[i] <= mag_in;
        fl2_d_r[i] <= fl1_d_r[ROOT_W-1];
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        mag_d_r[i] <= mag_d_r[i-1];
        fl2_d_r[i] <= fl2_d_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Finish 1: clamp to the first quadrant and unfold by signs
  // ---------------------------------------------------------------------
  logic             p1_v_r;
  logic [Q16_W-1:0] p1_yq_r, p1_pq_r, p1_yq_nxt, p1_pq_nxt;
  logic [W-1:0]     p1_mag_r;
  flags_t           p1_fl_r;
  flags_t           fl_c;
  logic [Q16_W-1:0] yaw_q, pit_q;

  always_comb begin
    fl_c  = fl2_d_r[CORDIC_STEPS-1];
    yaw_q = clamp_q16(yaw_ang);
    pit_q = clamp_q16(pit_ang);
    if (!fl_c.x_neg) begin
      p1_yq_nxt = fl_c.y_neg ? (Q16_W'(DEG360_Q16) - yaw_q) : yaw_q;
    end else begin
      p1_yq_nxt = fl_c.y_neg ? (Q16_W'(DEG180_Q16) + yaw_q)
                             : (Q16_W'(DEG180_Q16) - yaw_q);
    end
    // below the horizon the pitch reads from the top of the turn
    if (fl_c.z_neg && (pit_q != '0)) begin
      p1_pq_nxt = Q16_W'(DEG360_Q16) - pit_q;
    end else begin
      p1_pq_nxt = pit_q;
    end
  end

  // ---------------------------------------------------------------------
  // Finish 2: round to 1/256 deg, vertical case, negate the pitch
  // ---------------------------------------------------------------------
  logic                       out_valid_r;
  logic [W-1:0]               out_mag_r;
  logic [DEG_W-1:0]           out_yaw_r, out_yaw_nxt;
  logic signed [NPITCH_W-1:0] out_npitch_r, out_npitch_nxt;
  logic [DEG_W-1:0]           pitch_256;

  always_comb begin
    if (p1_fl_r.vertical) begin
      out_yaw_nxt = '0;
      pitch_256   = p1_fl_r.z_pos ? DEG_W'(PITCH_UP_256) : DEG_W'(PITCH_DOWN_256);
    end else begin
      out_yaw_nxt = to_256ths(p1_yq_r);
      pitch_256   = to_256ths(p1_pq_r);
    end
    out_npitch_nxt = -$signed({1'b0, pitch_256});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_v_r      <= yaw_v;
      out_valid_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_yq_r      <= p1_yq_nxt;
    p1_pq_r      <= p1_pq_nxt;
    p1_mag_r     <= mag_d_r[CORDIC_STEPS-1];
    p1_fl_r      <= fl_c;
    out_mag_r    <= p1_mag_r;
    out_yaw_r    <= out_yaw_nxt;
    out_npitch_r <= out_npitch_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;
  assign out_yaw_angle = out_yaw_r;
  assign out_neg_pitch = out_npitch_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // both root pipes must stay in step, the pitch CORDIC is fed by one of them
  a_sqrt_lockstep : assert property (@(posedge clk) disable iff (!rst_n)
    sqm_v == sqf_v)
    else $error("root pipes out of step");

  a_cordic_lockstep : assert property (@(posedge clk) disable iff (!rst_n)
    yaw_v == pit_v)
    else $error("CORDIC chains out of step");

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("item lost in the pipeline");

  a_out_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw_angle < TURN_256) && (out_neg_pitch <= 0) &&
                  (out_neg_pitch > -TURN_256))
    else $error("angle out of range");

  a_vertical_yaw : assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r && p1_fl_r.vertical) |=> (out_yaw_angle == '0))
    else $error("vertical item with non-zero yaw");

endmodule

### rtl/core/c2sa_sqrt.sv
// c2sa_sqrt: pipelined restoring integer square root, one root bit per stage.
// Depends on c2sa_pkg.
module c2sa_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  logic [c2sa_pkg::SQRT_W-1:0]   rad_i,
  output logic                          valid_o,
  output logic [c2sa_pkg::ROOT_W-1:0]   root_o
);
  import c2sa_pkg::*;

  logic              v_r   [ROOT_W];
  logic [SQRT_W-1:0] rem_r [ROOT_W];
  logic [SQRT_W-1:0] res_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SQRT_W - 2 - 2 * k);

    logic              v_in;
    logic [SQRT_W-1:0] rem_in;
    logic [SQRT_W-1:0] res_in;
    logic [SQRT_W-1:0] trial;
    logic              fits;
    logic [SQRT_W-1:0] rem_nxt;
    logic [SQRT_W-1:0] res_nxt;

    if (k == 0) begin : g_head
      assign v_in   = valid_i;
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_tail
      assign v_in   = v_r[k-1];
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    always_comb begin
      trial   = res_in + BIT;
      fits    = (rem_in >= trial);
      rem_nxt = fits ? (rem_in - trial) : rem_in;
      res_nxt = fits ? ((res_in >> 1) + BIT) : (res_in >> 1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      res_r[k] <= res_nxt;
    end
  end

  assign valid_o = v_r[ROOT_W-1];
  assign root_o  = res_r[ROOT_W-1][ROOT_W-1:0];

endmodule

### rtl/core/c2sa_cordic.sv
// c2sa_cordic: pipelined CORDIC vectoring chain, one micro-rotation per stage,
// returning the raw angle accumulator in 1/65536 deg. Depends on c2sa_pkg.
module c2sa_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                valid_i,
  input  logic [c2sa_pkg::CORDIC_W-1:0]       a_i,
  input  logic [c2sa_pkg::CORDIC_W-1:0]       b_i,
  output logic                                valid_o,
  output logic signed [c2sa_pkg::ANG_W-1:0]   ang_o
);
  import c2sa_pkg::*;

  logic                       v_r   [CORDIC_STEPS];
  logic [CORDIC_W-1:0]        a_r   [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] b_r   [CORDIC_STEPS];
  logic signed [ANG_W-1:0]    ang_r [CORDIC_STEPS];

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_stage
    localparam logic signed [ANG_W-1:0] STEP = $signed(ANG_W'(ATAN_TAB[s]));

    logic                       v_in;
    logic [CORDIC_W-1:0]        a_in;
    logic signed [CORDIC_W-1:0] b_in;
    logic signed [ANG_W-1:0]    ang_in;
    logic [CORDIC_W-1:0]        b_mag;
    logic [CORDIC_W-1:0]        b_sh;
    logic [CORDIC_W-1:0]        a_sh;
    logic [CORDIC_W-1:0]        a_nxt;
    logic signed [CORDIC_W-1:0] b_nxt;
    logic signed [ANG_W-1:0]    ang_nxt;

    if (s == 0) begin : g_head
      assign v_in   = valid_i;
      assign a_in   = a_i;
      assign b_in   = $signed(b_i);
      assign ang_in = '0;
    end else begin : g_tail
      assign v_in   = v_r[s-1];
      assign a_in   = a_r[s-1];
      assign b_in   = b_r[s-1];
      assign ang_in = ang_r[s-1];
    end

    // a never goes negative; b shifts toward zero on its magnitude
    always_comb begin
      b_mag   = b_in[CORDIC_W-1] ? $unsigned(-b_in) : $unsigned(b_in);
      b_sh    = b_mag >> s;
      a_sh    = a_in >> s;
      a_nxt   = a_in;
      b_nxt   = b_in;
      ang_nxt = ang_in;
      if (b_in != '0) begin
        a_nxt = a_in + b_sh;
        if (b_in[CORDIC_W-1]) begin
          b_nxt   = b_in + $signed(a_sh);
          ang_nxt = ang_in - STEP;
        end else begin
          b_nxt   = b_in - $signed(a_sh);
          ang_nxt = ang_in + STEP;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      a_r[s]   <= a_nxt;
      b_r[s]   <= b_nxt;
      ang_r[s] <= ang_nxt;
    end
  end

  assign valid_o = v_r[CORDIC_STEPS-1];
  assign ang_o   = ang_r[CORDIC_STEPS-1];

endmodule
